// ===== design/bba_pkg.sv =====
package bba_pkg;

    localparam int REQ_W      = 25;
    localparam int OFF_W      = 24;
    localparam int ORD_OUT_W  = 4;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 10;
    localparam int WORD_W     = 32;
    localparam int WORD_LOG2  = 5;

    localparam logic [CFG_W-1:0]  OH_RESET    = CFG_W'(24);
    localparam logic              ACT_ALLOC   = 1'b0;
    localparam logic              ACT_FREE    = 1'b1;
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic             action;
        logic [REQ_W-1:0] request_size;
        logic [OFF_W-1:0] release_offset;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OFF_W-1:0]     granted_offset;
        logic [ORD_OUT_W-1:0] granted_order;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_ORD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RMW_RD,
        S_RMW_WR,
        S_FIN_A,
        S_FCHK,
        S_FRD,
        S_MRG_RD,
        S_MRG_CHK,
        S_DONE
    } t_state;

endpackage

// ===== design/bba_chan_if.sv =====
interface bba_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/buddy_block_allocator.sv =====
// Buddy allocator over a region of 2^REGION_LOG2 bytes with blocks of at least
// 2^MIN_BLOCK_LOG2 bytes. The free map (one bit per block of every order, heap
// numbered, 32 bits to a word) and the per-minimum-block allocation table live in
// two single-port-read synchronous RAMs; per-order free counts are registers. One
// item is in flight at a time. An allocate rounds the size up order by order,
// skips empty orders, scans the free-map words of the first non-empty order,
// and then splits level by level. A free checks the offset, reads the
// allocation table, merges level by level, and ends with the final free-map update.
// Each free-map read-modify-write reads the word through the RAM read port and
// then writes it back. After reset a clearing pass over all 2^(REGION_LOG2-MIN_BLOCK_LOG2)
// allocation-table entries (16384 by default) initializes both RAMs; no request is
// accepted during it, while the overhead register can be written at any time.
module buddy_block_allocator import bba_pkg::*; #(
    parameter int REGION_LOG2    = 24,
    parameter int MIN_BLOCK_LOG2 = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bba_chan_if.sink         i_req,
    bba_chan_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);
    localparam int T      = REGION_LOG2 - MIN_BLOCK_LOG2;
    localparam int NODE_W = T + 1;
    localparam int OW     = $clog2(T + 1);
    localparam int FM_AW  = NODE_W - WORD_LOG2;
    localparam int FM_D   = 2 ** FM_AW;
    localparam int AO_D   = 2 ** T;
    localparam int AO_W   = $clog2(T + 2);
    localparam int NW     = (REGION_LOG2 + 2 > REQ_W + 1) ? REGION_LOG2 + 2 : REQ_W + 1;
    localparam int SW     = (REGION_LOG2 + 1 > OFF_W) ? REGION_LOG2 + 1 : OFF_W;

    t_state              r_state, n_state;
    logic [T-1:0]        r_clr;
    logic [CFG_W-1:0]    r_oh;
    logic [NW-1:0]       r_need, n_need;
    logic [NW-1:0]       r_lim, n_lim;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [OW-1:0]       r_ord, n_ord;
    logic [OW-1:0]       r_tgt, n_tgt;
    logic [OW-1:0]       r_orig, n_orig;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [FM_AW-1:0]    r_waddr, n_waddr;
    logic [T-1:0]        r_mb, n_mb;
    logic                r_split, n_split;
    t_rsp                r_res, n_res;
    logic                r_ov;
    t_rsp                r_out;
    logic [T:0]          r_cnt [T+1];
    logic                cnt_inc, cnt_dec, out_load;

    logic                fm_we;
    logic [FM_AW-1:0]    fm_waddr, fm_raddr;
    logic [WORD_W-1:0]   fm_wdata, fm_rdata;
    logic                ao_we;
    logic [T-1:0]        ao_waddr, ao_raddr;
    logic [AO_W-1:0]     ao_wdata, ao_rdata;

    bba_ram #(.WIDTH(WORD_W), .DEPTH(FM_D)) u_free_map (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (fm_wdata),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rdata)
    );

    bba_ram #(.WIDTH(AO_W), .DEPTH(AO_D)) u_alloc_tab (
        .i_clk   (i_clk),
        .i_we    (ao_we),
        .i_waddr (ao_waddr),
        .i_wdata (ao_wdata),
        .i_raddr (ao_raddr),
        .o_rdata (ao_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    always_comb begin
        int                  k;
        logic [NW-1:0]       need;
        logic [WORD_W-1:0]   mask, lo, m;
        logic [WORD_LOG2-1:0] fb;
        logic [NODE_W-1:0]   tnode, bud, fnode;
        logic [T-1:0]        minblk;
        logic [SW-1:0]       start;
        logic [OW-1:0]       vord;

        n_state  = r_state;
        n_need   = r_need;
        n_lim    = r_lim;
        n_off    = r_off;
        n_ord    = r_ord;
        n_tgt    = r_tgt;
        n_orig   = r_orig;
        n_node   = r_node;
        n_waddr  = r_waddr;
        n_mb     = r_mb;
        n_split  = r_split;
        n_res    = r_res;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        out_load = 1'b0;
        fm_we    = 1'b0;
        fm_waddr = r_waddr;
        fm_wdata = fm_rdata;
        ao_we    = 1'b0;
        ao_waddr = r_mb;
        ao_wdata = '0;

        k = T - int'(r_ord);
        lo = (WORD_W'(1) << (1 << k)) - WORD_W'(1);
        mask = (k >= WORD_LOG2) ? '1 : (lo << (1 << k));
        m = fm_rdata & mask;
        fb = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                fb = WORD_LOG2'(i);
            end
        end
        tnode  = r_node | NODE_W'(r_split);
        bud    = r_node ^ NODE_W'(1);
        minblk = T'(r_node << r_ord);
        need   = NW'(i_req.data.request_size) + NW'(r_oh);
        start  = SW'(r_off) - SW'(r_oh);
        vord   = OW'(ao_rdata - AO_W'(1));
        fnode  = NODE_W'({1'b1, r_mb} >> vord);
        fm_raddr = tnode[NODE_W-1:WORD_LOG2];
        ao_raddr = start[MIN_BLOCK_LOG2 +: T];

        unique case (r_state)
            S_CLEAR: begin
                ao_we    = 1'b1;
                ao_waddr = r_clr;
                ao_wdata = '0;
                if ((r_clr >> FM_AW) == '0) begin
                    fm_we    = 1'b1;
                    fm_waddr = FM_AW'(r_clr);
                    fm_wdata = (r_clr == '0) ? WORD_W'(2) : '0;
                end
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.data.action == ACT_FREE) begin
                        n_off   = i_req.data.release_offset;
                        n_state = S_FCHK;
                    end else if (need > (NW'(1) << REGION_LOG2)) begin
                        n_res   = '{ST_NO_FIT, '0, '0};
                        n_state = S_DONE;
                    end else begin
                        n_need  = need;
                        n_lim   = NW'(1) << MIN_BLOCK_LOG2;
                        n_ord   = '0;
                        n_state = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (r_ord != OW'(T) && r_need > r_lim) begin
                    n_ord = r_ord + OW'(1);
                    n_lim = r_lim << 1;
                end else begin
                    n_tgt   = r_ord;
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                if (r_cnt[r_ord] != '0) begin
                    n_waddr = FM_AW'((NODE_W'(1) << k) >> WORD_LOG2);
                    n_state = S_SCAN_RD;
                end else if (r_ord == OW'(T)) begin
                    n_res   = '{ST_NO_FIT, '0, '0};
                    n_state = S_DONE;
                end else begin
                    n_ord = r_ord + OW'(1);
                end
            end
            S_SCAN_RD: begin
                fm_raddr = r_waddr;
                n_state  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (m != '0) begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_rdata & ~(WORD_W'(1) << fb);
                    cnt_dec  = 1'b1;
                    if (r_ord == r_tgt) begin
                        n_node  = {r_waddr, fb};
                        n_state = S_FIN_A;
                    end else begin
                        n_ord   = r_ord - OW'(1);
                        n_node  = {r_waddr, fb} << 1;
                        n_split = 1'b1;
                        n_state = S_RMW_RD;
                    end
                end else begin
                    n_waddr = r_waddr + FM_AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                fm_we    = 1'b1;
                fm_waddr = tnode[NODE_W-1:WORD_LOG2];
                fm_wdata = fm_rdata | (WORD_W'(1) << tnode[WORD_LOG2-1:0]);
                cnt_inc  = !fm_rdata[tnode[WORD_LOG2-1:0]];
                if (!r_split) begin
                    n_res   = '{ST_OK, '0, ORD_OUT_W'(r_orig)};
                    n_state = S_DONE;
                end else if (r_ord == r_tgt) begin
                    n_state = S_FIN_A;
                end else begin
                    n_ord   = r_ord - OW'(1);
                    n_node  = r_node << 1;
                    n_state = S_RMW_RD;
                end
            end
            S_FIN_A: begin
                ao_we    = 1'b1;
                ao_waddr = minblk;
                ao_wdata = AO_W'(r_ord) + AO_W'(1);
                n_res    = '{ST_OK,
                             OFF_W'((SW'(minblk) << MIN_BLOCK_LOG2) + SW'(r_oh)),
                             ORD_OUT_W'(r_ord)};
                n_state  = S_DONE;
            end
            S_FCHK: begin
                if (r_off < OFF_W'(r_oh) || start[MIN_BLOCK_LOG2-1:0] != '0
                        || start >= (SW'(1) << REGION_LOG2)) begin
                    n_res   = '{ST_BAD_FREE, '0, '0};
                    n_state = S_DONE;
                end else begin
                    n_mb    = start[MIN_BLOCK_LOG2 +: T];
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                if (ao_rdata == '0 || ao_rdata > AO_W'(T + 1)) begin
                    n_res   = '{ST_BAD_FREE, '0, '0};
                    n_state = S_DONE;
                end else begin
                    ao_we   = 1'b1;
                    n_ord   = vord;
                    n_orig  = vord;
                    n_node  = fnode;
                    n_split = 1'b0;
                    n_state = (vord == OW'(T)) ? S_RMW_RD : S_MRG_RD;
                end
            end
            S_MRG_RD: begin
                fm_raddr = bud[NODE_W-1:WORD_LOG2];
                n_state  = S_MRG_CHK;
            end
            S_MRG_CHK: begin
                if (fm_rdata[bud[WORD_LOG2-1:0]]) begin
                    fm_we    = 1'b1;
                    fm_waddr = bud[NODE_W-1:WORD_LOG2];
                    fm_wdata = fm_rdata & ~(WORD_W'(1) << bud[WORD_LOG2-1:0]);
                    cnt_dec  = 1'b1;
                    n_node   = r_node >> 1;
                    n_ord    = r_ord + OW'(1);
                    n_state  = (r_ord + OW'(1) == OW'(T)) ? S_RMW_RD : S_MRG_RD;
                end else begin
                    n_state = S_RMW_RD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_oh    <= OH_RESET;
            r_ov    <= 1'b0;
            r_split <= 1'b0;
            for (int i = 0; i <= T; i++) begin
                r_cnt[i] <= (i == T) ? (T + 1)'(1) : '0;
            end
        end else begin
            r_state <= n_state;
            r_split <= n_split;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + T'(1);
            end
            if (i_cfg_we) begin
                r_oh <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (cnt_inc) begin
                r_cnt[r_ord] <= r_cnt[r_ord] + (T + 1)'(1);
            end else if (cnt_dec) begin
                r_cnt[r_ord] <= r_cnt[r_ord] - (T + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need  <= n_need;
        r_lim   <= n_lim;
        r_off   <= n_off;
        r_ord   <= n_ord;
        r_tgt   <= n_tgt;
        r_orig  <= n_orig;
        r_node  <= n_node;
        r_waddr <= n_waddr;
        r_mb    <= n_mb;
        r_res   <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // at most one whole-region block can ever be free
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt[T] <= (T + 1)'(1))
        else $error("top order free count above one");

    assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_CLEAR)
        else $error("reset did not start clearing pass");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.status != ST_OK
            |-> o_rsp.data.granted_offset == '0 && o_rsp.data.granted_order == '0)
        else $error("failed result carries offset or order");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.data.status == ST_OK || o_rsp.data.status == ST_NO_FIT
            || o_rsp.data.status == ST_BAD_FREE)
        else $error("undefined status code");
endmodule

// ===== bench/bba_checker.sv =====
module bba_checker import bba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bba_chan_if              req,
    bba_chan_if              rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output int               o_errors,
    output int               o_pending
);
    localparam int TOP    = 14;
    localparam int NODES  = (1 << (TOP + 1)) - 1;
    localparam int MINBLK = 1 << TOP;

    bit             free_bit[NODES];
    int unsigned    free_per_order[TOP + 1];
    bit [4:0]       start_order[MINBLK];
    logic [CFG_W-1:0] header_bytes;
    t_rsp           awaited_rsp[$];

    function automatic int node_index(int ord, int idx);
        return ((1 << (TOP - ord)) - 1) + idx;
    endfunction

    function automatic void mark_block(int ord, int idx, bit f);
        int n;
        n = node_index(ord, idx);
        if (n >= NODES) return;
        if (f && !free_bit[n]) free_per_order[ord]++;
        if (!f && free_bit[n]) free_per_order[ord]--;
        free_bit[n] = f;
    endfunction

    function automatic bit block_free(int ord, int idx);
        int n;
        n = node_index(ord, idx);
        return n < NODES && free_bit[n];
    endfunction

    function automatic void clear_pool();
        foreach (free_bit[i]) free_bit[i] = 0;
        foreach (free_per_order[i]) free_per_order[i] = 0;
        foreach (start_order[i]) start_order[i] = 0;
        header_bytes = OH_RESET;
        mark_block(TOP, 0, 1);
    endfunction

    function automatic t_rsp grant_block(logic [REQ_W-1:0] size);
        t_rsp r;
        longint need;
        int ord, j, idx, cnt;
        bit found;
        r = '0;
        r.status = ST_NO_FIT;
        need = longint'(size) + longint'(header_bytes);
        if (need > (longint'(1) << 24)) return r;
        ord = 0;
        while (ord < TOP && need > (longint'(1) << (ord + 10))) ord++;
        found = 0;
        idx = 0;
        for (j = ord; j <= TOP; j++) begin
            if (free_per_order[j] != 0) begin
                cnt = 1 << (TOP - j);
                for (idx = 0; idx < cnt; idx++) begin
                    if (block_free(j, idx)) begin
                        found = 1;
                        break;
                    end
                end
            end
            if (found) break;
        end
        if (!found) return r;
        mark_block(j, idx, 0);
        while (j > ord) begin
            j--;
            idx = idx << 1;
            mark_block(j, idx + 1, 1);
        end
        start_order[idx << ord] = 5'(ord + 1);
        r.status = ST_OK;
        r.granted_offset = OFF_W'((longint'(idx) << (ord + 10)) + longint'(header_bytes));
        r.granted_order = ORD_OUT_W'(ord);
        return r;
    endfunction

    function automatic t_rsp release_block(logic [OFF_W-1:0] off);
        t_rsp r;
        logic [OFF_W-1:0] start;
        int idx, ord, orig, bi;
        r = '0;
        r.status = ST_BAD_FREE;
        if (off < OFF_W'(header_bytes)) return r;
        start = off - OFF_W'(header_bytes);
        if (start[9:0] != 0) return r;
        idx = int'(start >> 10);
        if (start_order[idx] == 0 || start_order[idx] > TOP + 1) return r;
        orig = int'(start_order[idx]) - 1;
        start_order[idx] = 0;
        ord = orig;
        bi = idx >> ord;
        while (ord < TOP && block_free(ord, bi ^ 1)) begin
            mark_block(ord, bi ^ 1, 0);
            bi = bi >> 1;
            ord++;
        end
        mark_block(ord, bi, 1);
        r.status = ST_OK;
        r.granted_order = ORD_OUT_W'(orig);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        clear_pool();
    end

    assign o_pending = awaited_rsp.size();

    always @(posedge i_clk) begin
        t_rsp w, g;
        if (!i_rst_n) begin
            clear_pool();
            awaited_rsp.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                g = rsp.data;
                if (awaited_rsp.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(g), 0);
                end else begin
                    w = awaited_rsp.pop_front();
                    if (g.status !== w.status)
                        report_mismatch("status", 32'(g.status), 32'(w.status));
                    if (g.granted_offset !== w.granted_offset)
                        report_mismatch("offset", 32'(g.granted_offset), 32'(w.granted_offset));
                    if (g.granted_order !== w.granted_order)
                        report_mismatch("order", 32'(g.granted_order), 32'(w.granted_order));
                end
            end
            if (req.valid && req.ready) begin
                if (req.data.action == ACT_ALLOC)
                    awaited_rsp.push_back(grant_block(req.data.request_size));
                else
                    awaited_rsp.push_back(release_block(req.data.release_offset));
            end
            if (i_cfg_we) header_bytes = i_cfg_wdata;
        end
    end
endmodule

// ===== bench/buddy_block_allocator_tb.sv =====
module buddy_block_allocator_tb;
    import bba_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    int errors, pending;
    int sent, rcvd;
    bit quiet, long_hold;
    logic [CFG_W-1:0] cur_hdr;
    bit   sent_kind[$];
    int   live_start[$];

    bba_chan_if #(.t_payload(t_req)) req_ch ();
    bba_chan_if #(.t_payload(t_rsp)) rsp_ch ();

    buddy_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    bba_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req_ch), .rsp(rsp_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_errors(errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver side: random hold-offs, one long one on request
    initial begin
        int n;
        rsp_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                rsp_ch.ready = 0;
                for (n = 0; n < 400; n++) @(negedge i_clk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready = 0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1;
            end
        end
    end

    // track granted blocks so that frees can hit live ones
    always @(posedge i_clk) begin
        t_rsp r;
        bit k;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            r = rsp_ch.data;
            rcvd++;
            if (sent_kind.size() != 0) begin
                k = sent_kind.pop_front();
                if (k == ACT_ALLOC && r.status == ST_OK)
                    live_start.push_back(int'(r.granted_offset) - int'(cur_hdr));
            end
        end
    end

    task automatic send(logic act, logic [REQ_W-1:0] sz, logic [OFF_W-1:0] off);
        t_req t;
        t.action = act;
        t.request_size = sz;
        t.release_offset = off;
        req_ch.data = t;
        req_ch.valid = 1;
        sent_kind.push_back(act);
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_ch.valid = 0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        req_ch.valid = 0;
        while (rcvd != sent) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_header(logic [CFG_W-1:0] v);
        drain();
        i_cfg_we = 1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        i_cfg_wdata = CFG_W'($urandom);
        cur_hdr = v;
        live_start.delete();
    endtask

    task automatic free_live(int pick);
        int s;
        s = live_start[pick];
        live_start.delete(pick);
        send(ACT_FREE, REQ_W'($urandom), OFF_W'(s + int'(cur_hdr)));
    endtask

    task automatic random_item();
        int r;
        logic [REQ_W-1:0] sz;
        r = $urandom_range(0, 99);
        if (r < 45 || live_start.size() == 0) begin
            case ($urandom_range(0, 9))
                0: sz = REQ_W'($urandom);
                1: sz = REQ_W'($urandom_range(1 << 20, 1 << 24));
                2, 3: sz = REQ_W'($urandom_range(0, 1 << 16));
                default: sz = REQ_W'($urandom_range(0, 4096));
            endcase
            send(ACT_ALLOC, sz, OFF_W'($urandom));
        end else if (r < 85) begin
            free_live($urandom_range(0, live_start.size() - 1));
        end else if (r < 92) begin
            send(ACT_FREE, REQ_W'($urandom), OFF_W'($urandom));
        end else begin
            send(ACT_FREE, REQ_W'($urandom),
                 OFF_W'(($urandom_range(0, 16383) << 10) + int'(cur_hdr)));
        end
    endtask

    initial begin
        int ph;
        logic [CFG_W-1:0] hdrs[4];
        sent = 0;
        rcvd = 0;
        quiet = 0;
        long_hold = 0;
        cur_hdr = OH_RESET;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        req_ch.valid = 0;
        req_ch.data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // directed corner cases at the reset header size, then with headers of 0 and 0x3FF
        send(ACT_ALLOC, 0, 24'hFFFFFF);
        send(ACT_ALLOC, 25'h1000000, 0);
        send(ACT_ALLOC, 25'h1FFFFFF, 0);
        send(ACT_ALLOC, 1000, 0);
        send(ACT_ALLOC, 1001, 0);
        send(ACT_FREE, 25'h1FFFFFF, 24'h000018);
        send(ACT_FREE, 0, 24'h000018);
        send(ACT_FREE, 0, 24'h000000);
        send(ACT_FREE, 0, 24'h000019);
        send(ACT_FREE, 0, 24'hFFFFFF);
        send(ACT_FREE, 0, 24'h000818);
        send(ACT_FREE, 0, 24'h000418);
        send(ACT_ALLOC, 25'h1000000 - 24, 0);
        send(ACT_ALLOC, 0, 0);
        send(ACT_FREE, 0, 24'h000018);
        send(ACT_FREE, 0, 24'h000018);
        set_header(0);
        send(ACT_ALLOC, 25'h1000000, 0);
        send(ACT_FREE, 0, 0);
        send(ACT_ALLOC, 1024, 0);
        send(ACT_FREE, 0, 0);
        set_header(10'h3FF);
        send(ACT_ALLOC, 25'h1000000 - 1023, 0);
        send(ACT_ALLOC, 1, 0);
        send(ACT_FREE, 0, 24'h0003FF);
        set_header(OH_RESET);

        hdrs[0] = 24;
        hdrs[1] = 0;
        hdrs[2] = 10'h3FF;
        hdrs[3] = CFG_W'($urandom);
        for (ph = 0; ph < 4; ph++) begin
            set_header(hdrs[ph]);
            if (ph == 3) quiet = 1;
            repeat (100) begin
                if (ph == 1 && $urandom_range(0, 49) == 0 && !long_hold) long_hold = 1;
                random_item();
            end
            if (ph == 0) begin
                long_hold = 1;
                repeat (10) random_item();
            end
        end

        drain();
        repeat (100) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
